// ----- src/lgge_pkg.sv -----
// Package: operation codes, rule constants and the neighborhood window type for the life grid.
`timescale 1ns / 1ps
package lgge_pkg;

  // Input field widths
  localparam int ROW_W = 7;
  localparam int COL_W = 8;
  localparam int OP_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // Neighbor count and B3/S23 thresholds
  localparam int              CNT_W         = 4;
  localparam logic [CNT_W-1:0] BIRTH_CNT    = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_CNT  = 4'd2;

  // 3x3 neighborhood around the cell being judged
  typedef struct packed {
    logic nw;
    logic n;
    logic ne;
    logic w;
    logic ctr;
    logic e;
    logic sw;
    logic s;
    logic se;
  } window_t;

endpackage

// ----- src/life_grid_generation_engine_top.sv -----
// Top level of the life grid engine: command sequencer, row window and grid memory.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall): one transaction carries an operation,
//   in_op = write cell, read cell or advance one generation, with in_row,
//   in_col and in_cell_value. Every input transaction yields exactly one
//   output transaction on out_valid / out_stall carrying out_read_value
//   (the cell for a read, 0 otherwise; off-grid coordinates and the unused
//   op code give 0 and leave the grid alone).
//   The grid lives in a ROWS-deep RAM, one COLS-bit row per word.
//   Flow: one operation at a time, in_stall is high while one is in
//   flight. Read and write: the row is fetched, then used or written
//   back, through states RDWAIT and DONE to the output register. Off-grid
//   or unused op: straight to DONE. A generation step streams the grid row
//   by row through a three-row window, one cell per cycle through the shared
//   rule unit, each finished row written back in state WROW. Old rows are
//   held in the window before they are overwritten, so every cell sees the
//   previous generation.
//   Reset: a clearing pass writes every row dead, with in_stall high.
//   A stalled result waits in the output register; the sequencer
//   holds its finished result until the output register is free.
module life_grid_generation_engine_top #(
  parameter int ROWS = 90,
  parameter int COLS = 160
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lgge_pkg::OP_W-1:0]  in_op,
  input  logic [lgge_pkg::ROW_W-1:0] in_row,
  input  logic [lgge_pkg::COL_W-1:0] in_col,
  input  logic                       in_cell_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_read_value
);
  import lgge_pkg::*;

  localparam int RA_W = $clog2(ROWS);
  localparam int CA_W = $clog2(COLS);

  // sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWAIT = 4'd2;
  localparam logic [3:0] ST_LOAD1  = 4'd3;
  localparam logic [3:0] ST_LOAD2  = 4'd4;
  localparam logic [3:0] ST_RUN    = 4'd5;
  localparam logic [3:0] ST_WROW   = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;

  logic [3:0]      state_r, state_nxt;
  logic [RA_W-1:0] row_r, row_nxt;     // clear pass / step row counter
  logic [CA_W-1:0] col_r, col_nxt;     // step column counter
  logic            res_r, res_nxt;
  logic            is_read_r, is_read_nxt;
  logic [RA_W-1:0] addr_r, addr_nxt;
  logic [CA_W-1:0] cidx_r, cidx_nxt;
  logic            val_r, val_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_val_r, out_val_nxt;

  // three-row window, rotated one column per cycle; new row shifts in
  logic [COLS-1:0] above_r, above_nxt;
  logic [COLS-1:0] cur_r, cur_nxt;
  logic [COLS-1:0] below_r, below_nxt;
  logic [COLS-1:0] nrow_r, nrow_nxt;
  logic            lft_a_r, lft_a_nxt;
  logic            lft_c_r, lft_c_nxt;
  logic            lft_b_r, lft_b_nxt;

  // RAM port
  logic            wr_en, rd_en;
  logic [RA_W-1:0] wr_addr, rd_addr;
  logic [COLS-1:0] wr_data, rd_data;

  logic            in_acc, on_grid, last_col, last_row, fetch_ok, out_free;
  logic [COLS-1:0] row_mod;
  window_t         win;
  logic            alive;

  lgge_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgge_rule u_rule (
    .win   (win),
    .alive (alive)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign on_grid        = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
  assign last_col       = (col_r == CA_W'(COLS - 1));
  assign last_row       = (row_r == RA_W'(ROWS - 1));
  assign fetch_ok       = (32'(row_r) + 32'd2 < ROWS);
  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;

  // neighborhood; off-grid neighbors read as dead
  always_comb begin
    win.nw  = lft_a_r;
    win.n   = above_r[0];
    win.ne  = last_col ? 1'b0 : above_r[1];
    win.w   = lft_c_r;
    win.ctr = cur_r[0];
    win.e   = last_col ? 1'b0 : cur_r[1];
    win.sw  = lft_b_r;
    win.s   = below_r[0];
    win.se  = last_col ? 1'b0 : below_r[1];
  end

  // single-cell write merges into the fetched row
  always_comb begin
    row_mod         = rd_data;
    row_mod[cidx_r] = val_r;
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_nxt       = res_r;
    is_read_nxt   = is_read_r;
    addr_nxt      = addr_r;
    cidx_nxt      = cidx_r;
    val_nxt       = val_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    below_nxt     = below_r;
    nrow_nxt      = nrow_r;
    lft_a_nxt     = lft_a_r;
    lft_c_nxt     = lft_c_r;
    lft_b_nxt     = lft_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    wr_en         = 1'b0;
    wr_addr       = row_r;
    wr_data       = nrow_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (last_row) begin
          row_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + RA_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          res_nxt     = 1'b0;
          is_read_nxt = (in_op == OP_READ);
          addr_nxt    = RA_W'(in_row);
          cidx_nxt    = CA_W'(in_col);
          val_nxt     = in_cell_value;
          if (in_op == OP_STEP) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = ST_LOAD1;
          end else if ((in_op == OP_READ || in_op == OP_WRITE) && on_grid) begin
            rd_en     = 1'b1;
            rd_addr   = RA_W'(in_row);
            state_nxt = ST_RDWAIT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_RDWAIT: begin
        if (is_read_r) begin
          res_nxt = rd_data[cidx_r];
        end else begin
          wr_en   = 1'b1;
          wr_addr = addr_r;
          wr_data = row_mod;
        end
        state_nxt = ST_DONE;
      end

      ST_LOAD1: begin
        cur_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = RA_W'(1);
        state_nxt = ST_LOAD2;
      end

      ST_LOAD2: begin
        below_nxt = rd_data;
        above_nxt = '0;
        lft_a_nxt = 1'b0;
        lft_c_nxt = 1'b0;
        lft_b_nxt = 1'b0;
        row_nxt   = '0;
        col_nxt   = '0;
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        // prefetch the row two below; it lands before the window rotates
        if (col_r == '0 && fetch_ok) begin
          rd_en   = 1'b1;
          rd_addr = row_r + RA_W'(2);
        end
        lft_a_nxt = above_r[0];
        lft_c_nxt = cur_r[0];
        lft_b_nxt = below_r[0];
        above_nxt = {above_r[0], above_r[COLS-1:1]};
        cur_nxt   = {cur_r[0], cur_r[COLS-1:1]};
        below_nxt = {below_r[0], below_r[COLS-1:1]};
        nrow_nxt  = {alive, nrow_r[COLS-1:1]};
        if (last_col) begin
          state_nxt = ST_WROW;
        end else begin
          col_nxt = col_r + CA_W'(1);
        end
      end

      ST_WROW: begin
        wr_en     = 1'b1;
        above_nxt = cur_r;
        cur_nxt   = below_r;
        below_nxt = fetch_ok ? rd_data : '0;
        lft_a_nxt = 1'b0;
        lft_c_nxt = 1'b0;
        lft_b_nxt = 1'b0;
        col_nxt   = '0;
        if (last_row) begin
          state_nxt = ST_DONE;
        end else begin
          row_nxt   = row_r + RA_W'(1);
          state_nxt = ST_RUN;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    is_read_r <= is_read_nxt;
    addr_r    <= addr_nxt;
    cidx_r    <= cidx_nxt;
    val_r     <= val_nxt;
    out_val_r <= out_val_nxt;
    above_r   <= above_nxt;
    cur_r     <= cur_nxt;
    below_r   <= below_nxt;
    nrow_r    <= nrow_nxt;
    lft_a_r   <= lft_a_nxt;
    lft_c_r   <= lft_c_nxt;
    lft_b_r   <= lft_b_nxt;
  end

endmodule

// ----- src/lgge_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lgge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lgge_rule.sv -----
// Shared cell update unit: counts live neighbors and applies the B3/S23 rule.
`timescale 1ns / 1ps
module lgge_rule (
  input  lgge_pkg::window_t win,
  output logic              alive
);
  import lgge_pkg::*;

  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt = CNT_W'(win.nw) + CNT_W'(win.n) + CNT_W'(win.ne) + CNT_W'(win.w)
        + CNT_W'(win.e) + CNT_W'(win.sw) + CNT_W'(win.s) + CNT_W'(win.se);
    alive = (cnt == BIRTH_CNT) || (win.ctr && (cnt == SURVIVE_CNT));
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for the life grid engine: directed and random cell operations checked against a grid model.
`timescale 1ns / 1ps
module tb;
  import lgge_pkg::*;

  // Grid size, kept at the block defaults
  localparam int GRID_ROWS = 90;
  localparam int GRID_COLS = 160;

  // Unused op code: the block must answer 0 and leave the grid alone
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // A whole step runs with nothing accepted on either side, so the limit
  // is set above the length of a step.
  localparam int WATCHDOG_LIMIT = 60000;
  // Long receiver hold-off: starts after this many results, lasts this many cycles
  localparam int LONG_HOLD_AT = 3;
  localparam int LONG_HOLD_CYCLES = 300;
  // Quiet time after the last result before the verdict
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 100;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
    int unsigned      gap;    // idle cycles before this transaction is offered
    bit               drain;  // hold off until every result is back
  } life_cmd_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_op;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_cell_value;
  logic             out_valid;
  logic             out_stall;
  logic             out_read_value;

  life_grid_generation_engine_top #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value)
  );

  // Model of the grid: current generation, one packed word per row
  bit [GRID_COLS-1:0] life_now [GRID_ROWS];

  life_cmd_t   cmd_q[$];         // transactions still to be offered
  bit          read_value_q[$];  // predicted read_value, oldest first
  int unsigned err_cnt = 0;
  int unsigned items_queued = 0;

  // Handshake flags: set at the rising edge, consumed at the falling edge
  bit          in_done = 1'b0;
  bit          out_done = 1'b0;

  // Driver state
  int unsigned gap_left = 0;
  bit          gap_armed = 1'b0;

  // Receiver state
  int unsigned results_seen = 0;
  int unsigned rx_hold = 0;
  int unsigned long_hold = 0;
  bit          rx_quiet = 1'b0;

  int unsigned idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Grid model
  // ---------------------------------------------------------------------------

  // One B3/S23 generation. Every cell is judged against a snapshot of the old
  // grid; neighbors off the edge count as dead, no wrap-around.
  function automatic void advance_generation();
    bit [GRID_COLS-1:0] snap [GRID_ROWS];
    int nbrs;
    int rr;
    int cc;
    snap = life_now;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        nbrs = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                cc >= 0 && cc < GRID_COLS) begin
              nbrs += snap[rr][cc];
            end
          end
        end
        if (nbrs == BIRTH_CNT) begin
          life_now[r][c] = 1'b1;
        end else if (nbrs != SURVIVE_CNT) begin
          life_now[r][c] = 1'b0;
        end
      end
    end
  endfunction

  // Applies one accepted operation to the model and returns its read_value
  function automatic bit apply_life_op(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                       logic [COL_W-1:0] col, logic value);
    bit on_grid;
    bit rd;
    on_grid = (row < GRID_ROWS) && (col < GRID_COLS);
    rd = 1'b0;
    case (op)
      OP_WRITE: begin
        if (on_grid) life_now[row][col] = value;
      end
      OP_READ: begin
        if (on_grid) rd = life_now[row][col];
      end
      OP_STEP: begin
        advance_generation();
      end
      default: ;  // unused code: nothing happens
    endcase
    return rd;
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, int row, int col, int value,
                          int unsigned gap, bit drain);
    life_cmd_t cmd;
    cmd.op    = op;
    cmd.row   = row[ROW_W-1:0];   // negative offsets wrap to off-grid rows
    cmd.col   = col[COL_W-1:0];
    cmd.value = value[0];
    cmd.gap   = gap;
    cmd.drain = drain;
    cmd_q.push_back(cmd);
    items_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_WRITE;
    in_row        = '0;
    in_col        = '0;
    in_cell_value = 1'b0;
    out_stall     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Input driver: offers the queued transactions at the falling edge. The next
  // valid is worked out first so in_valid gets a single assignment per edge.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    logic      nv;
    life_cmd_t nxt;
    nv = in_valid;
    if (in_done) begin
      in_done = 1'b0;
      nv = 1'b0;
    end
    if (rst_n && !nv && cmd_q.size() != 0) begin
      if (!gap_armed) begin
        gap_left  = cmd_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (!cmd_q[0].drain || read_value_q.size() == 0) begin
        nxt = cmd_q.pop_front();
        in_op         <= nxt.op;
        in_row        <= nxt.row;
        in_col        <= nxt.col;
        in_cell_value <= nxt.value;
        nv = 1'b1;
        gap_armed = 1'b0;
      end
    end
    in_valid <= nv;
  end

  // ---------------------------------------------------------------------------
  // Receiver: drives out_stall at the falling edge. Each result is held for a
  // random number of valid cycles; now and then it drops into a quiet stretch
  // with no stalls, and once it holds off for a long stretch regardless of
  // out_valid so that the block backs up into in_stall.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_done) begin
        out_done = 1'b0;
        results_seen++;
        if (results_seen == LONG_HOLD_AT) long_hold = LONG_HOLD_CYCLES;
        if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 8);
      end
      if (long_hold != 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (rx_hold != 0) begin
        if (out_valid) rx_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, an accepted input transaction updates the
  // model and queues its prediction; an accepted result is checked against
  // the oldest prediction.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    bit want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        read_value_q.push_back(apply_life_op(in_op, in_row, in_col, in_cell_value));
        in_done = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (read_value_q.size() == 0) begin
          $error("read_value: no transaction expected, actual %0b", out_read_value);
          err_cnt++;
        end else begin
          want = read_value_q.pop_front();
          if (out_read_value !== want) begin
            $error("read_value mismatch: expected %0b, actual %0b", want, out_read_value);
            err_cnt++;
          end
        end
        out_done = 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("life_grid_generation_engine_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------

  initial begin
    int  base_r;
    int  base_c;
    int  n_wr;
    int  n_rd;
    int  n_step;
    int  gap_max;
    bit  first;
    logic [OP_W-1:0] nop;

    // Directed part, back to back so the long receiver hold-off fills the block.
    // Opposite corners, written then read back.
    push_cmd(OP_WRITE, 0, 0, 1, 0, 0);
    push_cmd(OP_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, GRID_ROWS - 1, GRID_COLS - 1, 1, 0, 0);
    // Unused op code with every field at its top value
    push_cmd(OP_NONE, 127, 255, 1, 0, 0);
    // Off-grid writes are dropped, off-grid reads give 0
    push_cmd(OP_WRITE, GRID_ROWS, 0, 1, 0, 0);
    push_cmd(OP_WRITE, 0, GRID_COLS, 1, 0, 0);
    push_cmd(OP_READ, GRID_ROWS, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, GRID_COLS, 1, 0, 0);
    push_cmd(OP_READ, 127, 255, 0, 0, 0);
    // Blinker along the top edge: the half above the grid must not appear,
    // and nothing wraps to the bottom row. Lone corner cells die.
    push_cmd(OP_WRITE, 0, 10, 1, 0, 0);
    push_cmd(OP_WRITE, 0, 11, 1, 0, 0);
    push_cmd(OP_WRITE, 0, 12, 1, 0, 0);
    push_cmd(OP_STEP, 127, 255, 1, 0, 0);
    push_cmd(OP_READ, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 11, 0, 0, 0);
    push_cmd(OP_READ, 1, 11, 0, 0, 0);
    push_cmd(OP_READ, 0, 10, 0, 0, 0);
    push_cmd(OP_READ, GRID_ROWS - 1, 11, 0, 0, 0);
    // Writing a dead value, then another generation of the lone cell left
    push_cmd(OP_WRITE, 1, 11, 0, 0, 0);
    push_cmd(OP_READ, 1, 11, 1, 0, 0);
    push_cmd(OP_STEP, 0, 0, 0, 0, 0);
    push_cmd(OP_READ, 0, 11, 0, 0, 0);

    // Random part: mostly small patterns near edges or anywhere, one or two
    // generations, then reads around them; some noise with any coordinates.
    first = 1'b1;
    while (items_queued < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          base_r = $urandom_range(0, 1) ? 0 : GRID_ROWS - 5;
          base_c = $urandom_range(0, 1) ? 0 : GRID_COLS - 5;
        end else begin
          base_r = $urandom_range(0, GRID_ROWS - 5);
          base_c = $urandom_range(0, GRID_COLS - 5);
        end
        n_wr   = $urandom_range(5, 9);
        n_rd   = $urandom_range(4, 6);
        n_step = ($urandom_range(0, 3) == 0) ? 2 : 1;
        for (int i = 0; i < n_wr; i++) begin
          push_cmd(OP_WRITE, base_r + $urandom_range(0, 4), base_c + $urandom_range(0, 4),
                   ($urandom_range(0, 3) != 0), $urandom_range(0, gap_max),
                   first || (i == 0 && $urandom_range(0, 2) == 0));
          first = 1'b0;
        end
        for (int i = 0; i < n_step; i++) begin
          push_cmd(OP_STEP, $urandom_range(0, 127), $urandom_range(0, 255),
                   $urandom_range(0, 1), $urandom_range(0, gap_max), 0);
        end
        for (int i = 0; i < n_rd; i++) begin
          push_cmd(OP_READ, base_r - 1 + $urandom_range(0, 6),
                   base_c - 1 + $urandom_range(0, 6), $urandom_range(0, 1),
                   $urandom_range(0, gap_max), 0);
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          nop = OP_W'($urandom_range(0, 3));
          if (nop == OP_STEP) nop = OP_NONE;
          push_cmd(nop, $urandom_range(0, 127), $urandom_range(0, 255),
                   $urandom_range(0, 1), $urandom_range(0, gap_max), 0);
        end
      end
    end

    // Every transaction offered and taken, every result back, then a quiet tail
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || read_value_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("life_grid_generation_engine_top test passed");
    end else begin
      $display("life_grid_generation_engine_top test failed");
    end
    $finish;
  end

endmodule
